// ----- rtl/mfgd_pkg.sv -----
// ----------------------------------------------------------------------------
// mfgd_pkg
// shared widths, command codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package mfgd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int STATE_W    = 48;
  localparam int LEN_W      = 13;
  localparam int SYM_W      = 4;
  localparam int TIDX_W     = 4;
  localparam int DIG_W      = 16;
  localparam int FRAC_W     = 14;
  localparam int MUL_A_W    = DIG_W + 1;
  localparam int MUL_B_W    = STATE_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int MAG_PROD_W = DIG_W + STATE_W;
  localparam int ACC_W      = 112;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEFF  = 1'b1;

  // power sweep steps of the shared multiplier
  typedef enum logic [3:0] {
    STEP_CQ,
    STEP_A0,
    STEP_A1,
    STEP_A2,
    STEP_B0,
    STEP_B1,
    STEP_B2,
    STEP_C0,
    STEP_C1,
    STEP_C2,
    STEP_C3
  } step_t;

  typedef struct packed {
    logic  coef_we;
    logic  x_load;
    logic  upd_issue;
    logic  pwr_rd;
    logic  pwr_ld;
    logic  mul_vld;
    step_t step;
    logic  cmp;
    logic  clear;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic upd_busy;
  } dp_sts_t;

endpackage

// ----- rtl/mfgd_ram.sv -----
// ----------------------------------------------------------------------------
// mfgd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mfgd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mfgd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfgd_ctrl
// sequencer: filter update sweep, chunk counting, power sweep and result slot
// ----------------------------------------------------------------------------
module mfgd_ctrl #(
  parameter int NUM_TONES          = 16,
  parameter int MAX_SYMBOL_SAMPLES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         cfg_wr_en,
  input  logic [mfgd_pkg::LEN_W-1:0]   cfg_wr_data,
  output mfgd_pkg::dp_cmd_t            dp_cmd,
  output logic [$clog2(NUM_TONES)-1:0] tone_addr,
  input  mfgd_pkg::dp_sts_t            dp_sts
);

  import mfgd_pkg::*;

  localparam int TW   = $clog2(NUM_TONES);
  localparam int CW   = $clog2(MAX_SYMBOL_SAMPLES);
  localparam int MW   = $clog2(MAX_SYMBOL_SAMPLES + 1);
  localparam int LW   = ((MW > LEN_W) ? MW : LEN_W) + 1;
  localparam logic [TW-1:0] K_LAST  = TW'(NUM_TONES - 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_SYMBOL_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_UDRN,
    S_PRD,
    S_PLD,
    S_PMUL,
    S_PACC,
    S_PCMP,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [TW-1:0]      k_r, k_nxt;
  step_t              step_r, step_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [LW-1:0]      len_raw;
  logic [LW-1:0]      len_eff;
  logic [LW-1:0]      cnt_p1;
  logic               chunk_end;
  logic               accept;

  always_comb begin
    len_raw   = LW'(len_r);
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_raw;
    end
    cnt_p1    = LW'(cnt_r) + LW'(1);
    chunk_end = !(cnt_p1 < len_eff);
  end

  assign accept = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    dp_cmd        = '0;

    if (cfg_wr_en) begin
      len_nxt = cfg_wr_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_COEFF) begin
            dp_cmd.coef_we = 1'b1;
          end else begin
            dp_cmd.x_load = 1'b1;
            k_nxt         = '0;
            state_nxt     = S_UPD;
          end
        end
      end
      S_UPD: begin
        dp_cmd.upd_issue = 1'b1;
        if (k_r == K_LAST) begin
          k_nxt     = '0;
          state_nxt = S_UDRN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_UDRN: begin
        if (!dp_sts.upd_busy) begin
          if (chunk_end) begin
            cnt_nxt   = '0;
            k_nxt     = '0;
            state_nxt = S_PRD;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_PRD: begin
        dp_cmd.pwr_rd = 1'b1;
        state_nxt     = S_PLD;
      end
      S_PLD: begin
        dp_cmd.pwr_ld = 1'b1;
        step_nxt      = STEP_CQ;
        state_nxt     = S_PMUL;
      end
      S_PMUL: begin
        dp_cmd.mul_vld = 1'b1;
        dp_cmd.step    = step_r;
        if (step_r == STEP_C3) begin
          state_nxt = S_PACC;
        end else begin
          step_nxt = step_t'(step_r + 1'b1);
        end
      end
      S_PACC: begin
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        dp_cmd.cmp = 1'b1;
        if (k_r == K_LAST) begin
          dp_cmd.clear = 1'b1;
          k_nxt        = '0;
          state_nxt    = S_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          dp_cmd.emit   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      step_r      <= STEP_CQ;
      cnt_r       <= '0;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign tone_addr = k_r;

endmodule

// ----- rtl/mfgd_dpath.sv -----
// ----------------------------------------------------------------------------
// mfgd_dpath
// filter state and coefficient rams, shared 17x49 multiplier, update pipe,
// power accumulator and strongest-tone tracking
// ----------------------------------------------------------------------------
module mfgd_dpath #(
  parameter int NUM_TONES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mfgd_pkg::dp_cmd_t                   dp_cmd,
  input  logic [$clog2(NUM_TONES)-1:0]        tone_addr,
  output mfgd_pkg::dp_sts_t                   dp_sts,
  input  logic signed [mfgd_pkg::SAMPLE_W-1:0] in_pcm_sample,
  input  logic [mfgd_pkg::TIDX_W-1:0]         in_tone_index,
  input  logic signed [mfgd_pkg::COEFF_W-1:0] in_tone_coeff,
  output logic [mfgd_pkg::SYM_W-1:0]          out_symbol
);

  import mfgd_pkg::*;

  localparam int TW    = $clog2(NUM_TONES);
  localparam int IW    = ((TW > TIDX_W) ? TW : TIDX_W) + 1;
  localparam int SW    = 2 * STATE_W;
  localparam int RND_W = MAG_PROD_W - FRAC_W;
  localparam int SUM_W = STATE_W + 4;
  localparam logic signed [MAG_PROD_W-1:0] ROUND_HALF =
    MAG_PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W - 1){1'b1}}};
  localparam logic [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W - 1){1'b0}}};

  // rams
  logic [IW-1:0]               tidx_ext;
  logic                        tidx_ok;
  logic                        rd_en;
  logic [COEFF_W-1:0]          coef_rdata;
  logic [SW-1:0]               st_rdata;
  logic [SW-1:0]               st_wdata;

  // read side
  logic [NUM_TONES-1:0]        vld_r;
  logic                        rd_vld_r;
  logic signed [COEFF_W-1:0]   c_rd;
  logic signed [STATE_W-1:0]   q1_rd;
  logic signed [STATE_W-1:0]   q2_rd;

  // update pipe
  logic                        v1_r, v2_r, v3_r;
  logic [TW-1:0]               k1_r, k2_r, k3_r;
  logic signed [STATE_W-1:0]   q1_2r, q2_2r, q1_3r, q2_3r;
  logic signed [SAMPLE_W-1:0]  x_r;
  logic signed [MAG_PROD_W-1:0] sp_r;
  logic signed [RND_W-1:0]     rnd;
  logic signed [SUM_W-1:0]     sum;
  logic [STATE_W-1:0]          q0_sat;

  // multiplier
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [PROD_W-1:0]    prod_r;
  step_t                       ptag_r;
  logic                        pvld_r;

  // power
  logic [COEFF_W-1:0]          cmag_r;
  logic [STATE_W-1:0]          q1m_r, q2m_r;
  logic                        neg_r;
  logic [MAG_PROD_W-1:0]       cq_r;
  logic [ACC_W-1:0]            pw;
  logic [ACC_W-1:0]            addend;
  logic                        acc_add, acc_sub;
  logic [ACC_W-1:0]            acc_r, acc_nxt;
  logic [ACC_W-1:0]            best_r;
  logic [TW-1:0]               best_idx_r;
  logic [IW-1:0]               best_ext;
  logic [SYM_W-1:0]            sym_r;

  assign tidx_ext = IW'(in_tone_index);
  assign tidx_ok  = (tidx_ext < IW'(NUM_TONES));
  assign rd_en    = dp_cmd.upd_issue || dp_cmd.pwr_rd;

  mfgd_ram #(
    .WIDTH (COEFF_W),
    .DEPTH (NUM_TONES)
  ) u_coef_ram (
    .clk   (clk),
    .we    (dp_cmd.coef_we && tidx_ok),
    .waddr (tidx_ext[TW-1:0]),
    .wdata (in_tone_coeff),
    .re    (rd_en),
    .raddr (tone_addr),
    .rdata (coef_rdata)
  );

  assign st_wdata = {q0_sat, q1_3r};

  mfgd_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_TONES)
  ) u_state_ram (
    .clk   (clk),
    .we    (v3_r),
    .waddr (k3_r),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (tone_addr),
    .rdata (st_rdata)
  );

  // state entries not written since the last clear read as zero
  assign c_rd  = coef_rdata;
  assign q1_rd = rd_vld_r ? st_rdata[SW-1:STATE_W] : '0;
  assign q2_rd = rd_vld_r ? st_rdata[STATE_W-1:0] : '0;

  always_comb begin
    mul_a = {c_rd[COEFF_W-1], c_rd};
    mul_b = {q1_rd[STATE_W-1], q1_rd};
    if (dp_cmd.mul_vld) begin
      case (dp_cmd.step)
        STEP_CQ: begin
          mul_a = {1'b0, cmag_r};
          mul_b = {1'b0, q1m_r};
        end
        STEP_A0: begin
          mul_a = {1'b0, q1m_r[DIG_W-1:0]};
          mul_b = {1'b0, q1m_r};
        end
        STEP_A1: begin
          mul_a = {1'b0, q1m_r[2*DIG_W-1:DIG_W]};
          mul_b = {1'b0, q1m_r};
        end
        STEP_A2: begin
          mul_a = {1'b0, q1m_r[3*DIG_W-1:2*DIG_W]};
          mul_b = {1'b0, q1m_r};
        end
        STEP_B0: begin
          mul_a = {1'b0, q2m_r[DIG_W-1:0]};
          mul_b = {1'b0, q2m_r};
        end
        STEP_B1: begin
          mul_a = {1'b0, q2m_r[2*DIG_W-1:DIG_W]};
          mul_b = {1'b0, q2m_r};
        end
        STEP_B2: begin
          mul_a = {1'b0, q2m_r[3*DIG_W-1:2*DIG_W]};
          mul_b = {1'b0, q2m_r};
        end
        STEP_C0: begin
          mul_a = {1'b0, cq_r[DIG_W-1:0]};
          mul_b = {1'b0, q2m_r};
        end
        STEP_C1: begin
          mul_a = {1'b0, cq_r[2*DIG_W-1:DIG_W]};
          mul_b = {1'b0, q2m_r};
        end
        STEP_C2: begin
          mul_a = {1'b0, cq_r[3*DIG_W-1:2*DIG_W]};
          mul_b = {1'b0, q2m_r};
        end
        STEP_C3: begin
          mul_a = {1'b0, cq_r[4*DIG_W-1:3*DIG_W]};
          mul_b = {1'b0, q2m_r};
        end
        default: begin
          mul_a = {c_rd[COEFF_W-1], c_rd};
          mul_b = {q1_rd[STATE_W-1], q1_rd};
        end
      endcase
    end
  end

  assign prod_nxt = mul_a * mul_b;

  // update: q0 = sat(floor((c*q1 + half) / 2^14) - q2 + x)
  always_comb begin
    rnd = sp_r[MAG_PROD_W-1:FRAC_W];
    sum = SUM_W'(rnd) - SUM_W'(q2_3r) + SUM_W'(x_r);
    if ((&sum[SUM_W-1:STATE_W-1]) || !(|sum[SUM_W-1:STATE_W-1])) begin
      q0_sat = sum[STATE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      q0_sat = ST_MIN;
    end else begin
      q0_sat = ST_MAX;
    end
  end

  // power: (q1^2 + q2^2) * 2^14 -/+ |c*q1| * |q2|, one partial product a step
  always_comb begin
    pw      = ACC_W'(prod_r[MAG_PROD_W-1:0]);
    addend  = pw;
    acc_add = 1'b0;
    acc_sub = 1'b0;
    case (ptag_r)
      STEP_A0, STEP_B0: begin
        addend  = pw << FRAC_W;
        acc_add = 1'b1;
      end
      STEP_A1, STEP_B1: begin
        addend  = pw << (DIG_W + FRAC_W);
        acc_add = 1'b1;
      end
      STEP_A2, STEP_B2: begin
        addend  = pw << (2 * DIG_W + FRAC_W);
        acc_add = 1'b1;
      end
      STEP_C0: begin
        addend  = pw;
        acc_add = neg_r;
        acc_sub = !neg_r;
      end
      STEP_C1: begin
        addend  = pw << DIG_W;
        acc_add = neg_r;
        acc_sub = !neg_r;
      end
      STEP_C2: begin
        addend  = pw << (2 * DIG_W);
        acc_add = neg_r;
        acc_sub = !neg_r;
      end
      STEP_C3: begin
        addend  = pw << (3 * DIG_W);
        acc_add = neg_r;
        acc_sub = !neg_r;
      end
      default: begin
        addend  = pw;
      end
    endcase

    acc_nxt = acc_r;
    if (dp_cmd.pwr_ld) begin
      acc_nxt = '0;
    end else if (pvld_r && acc_add) begin
      acc_nxt = acc_r + addend;
    end else if (pvld_r && acc_sub) begin
      acc_nxt = acc_r - addend;
    end
  end

  assign best_ext = IW'(best_idx_r);

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      pvld_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      v1_r   <= dp_cmd.upd_issue;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      pvld_r <= dp_cmd.mul_vld;
      if (dp_cmd.clear) begin
        vld_r <= '0;
      end else if (v3_r) begin
        vld_r[k3_r] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= vld_r[tone_addr];
    end
    if (dp_cmd.x_load) begin
      x_r <= in_pcm_sample;
    end
    k1_r   <= tone_addr;
    k2_r   <= k1_r;
    k3_r   <= k2_r;
    q1_2r  <= q1_rd;
    q2_2r  <= q2_rd;
    q1_3r  <= q1_2r;
    q2_3r  <= q2_2r;
    prod_r <= prod_nxt;
    ptag_r <= dp_cmd.step;
    sp_r   <= $signed(prod_r[MAG_PROD_W-1:0]) + ROUND_HALF;
    acc_r  <= acc_nxt;
    if (dp_cmd.pwr_ld) begin
      cmag_r <= c_rd[COEFF_W-1] ? COEFF_W'(-c_rd) : c_rd;
      q1m_r  <= q1_rd[STATE_W-1] ? STATE_W'(-q1_rd) : q1_rd;
      q2m_r  <= q2_rd[STATE_W-1] ? STATE_W'(-q2_rd) : q2_rd;
      neg_r  <= c_rd[COEFF_W-1] ^ q1_rd[STATE_W-1] ^ q2_rd[STATE_W-1];
    end
    if (pvld_r && (ptag_r == STEP_CQ)) begin
      cq_r <= prod_r[MAG_PROD_W-1:0];
    end
    // lowest index wins a tie
    if (dp_cmd.cmp && ((tone_addr == '0) || (acc_r > best_r))) begin
      best_r     <= acc_r;
      best_idx_r <= tone_addr;
    end
    if (dp_cmd.emit) begin
      sym_r <= best_ext[SYM_W-1:0];
    end
  end

  assign dp_sts.upd_busy = v1_r || v2_r || v3_r;
  assign out_symbol      = sym_r;

endmodule

// ----- rtl/mfsk16_goertzel_symbol_detector_core.sv -----
// ----------------------------------------------------------------------------
// a coefficient load does not stall the input; a sample stalls it for a sweep
// of every tone through the one-read-port state ram and the 3-stage update pipe
// a chunk-ending sample then runs the power sweep and emits the result, after
// any wait for an earlier result held by out_stall;
// each tone's power takes 11 partial products on the one shared 17x49 multiplier
// sync active-low reset clears control, filter state and length (1024)
// ----------------------------------------------------------------------------
module mfsk16_goertzel_symbol_detector_core #(
  parameter int NUM_TONES          = 16,
  parameter int MAX_SYMBOL_SAMPLES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic signed [mfgd_pkg::SAMPLE_W-1:0] in_pcm_sample,
  input  logic [mfgd_pkg::TIDX_W-1:0]         in_tone_index,
  input  logic signed [mfgd_pkg::COEFF_W-1:0] in_tone_coeff,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mfgd_pkg::SYM_W-1:0]          out_symbol,
  input  logic                                cfg_wr_en,
  input  logic [mfgd_pkg::LEN_W-1:0]          cfg_wr_data
);

  import mfgd_pkg::*;

  dp_cmd_t                      dp_cmd;
  dp_sts_t                      dp_sts;
  logic [$clog2(NUM_TONES)-1:0] tone_addr;

  mfgd_ctrl #(
    .NUM_TONES          (NUM_TONES),
    .MAX_SYMBOL_SAMPLES (MAX_SYMBOL_SAMPLES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .dp_cmd      (dp_cmd),
    .tone_addr   (tone_addr),
    .dp_sts      (dp_sts)
  );

  mfgd_dpath #(
    .NUM_TONES (NUM_TONES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .dp_cmd        (dp_cmd),
    .tone_addr     (tone_addr),
    .dp_sts        (dp_sts),
    .in_pcm_sample (in_pcm_sample),
    .in_tone_index (in_tone_index),
    .in_tone_coeff (in_tone_coeff),
    .out_symbol    (out_symbol)
  );

endmodule

// ----- rtl/mfgd_chk.sv -----
// ----------------------------------------------------------------------------
// mfgd_chk
// port-level checks of the detector core, bound to the top level
// ----------------------------------------------------------------------------
module mfgd_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mfgd_pkg::SYM_W-1:0] out_symbol
);

  import mfgd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol))
    else $error("stalled result changed");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // coefficient load never blocks the next item
  a_coef_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd == CMD_COEFF) |=> !in_stall)
    else $error("coefficient load stalled input");

  // a sample item starts a filter sweep
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd == CMD_SAMPLE) |=> in_stall)
    else $error("sample item did not start a sweep");

  // a result only appears at the end of a busy period
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind mfsk16_goertzel_symbol_detector_core mfgd_chk u_mfgd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_cmd     (in_cmd),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_symbol (out_symbol)
);

// ----- tb/tb_mfsk16_goertzel_symbol_detector_core.sv -----
// ----------------------------------------------------------------------------
// tb_mfsk16_goertzel_symbol_detector_core
// Sends coefficient loads and PCM samples to the sixteen-tone Goertzel
// symbol detector and predicts every symbol with an exact 48-bit filter
// and 130-bit power model. Sender and receiver idle and stall at random.
// Chunk length changes between phases, including 0 and the largest
// 13-bit value.
// ----------------------------------------------------------------------------
module tb_mfsk16_goertzel_symbol_detector_core;
  import mfgd_pkg::*;

  localparam int NTONES      = 16;
  localparam int MAX_SAMPLES = 4096;
  localparam int SETTLE      = 300;
  localparam int LONG_HOLD   = 1200;
  localparam int QUIET_LIMIT = 4000;

  class tone_scoreboard;
    logic signed [COEFF_W-1:0] coeff_tab [NTONES];
    logic signed [STATE_W-1:0] q1 [NTONES];
    logic signed [STATE_W-1:0] q2 [NTONES];
    int unsigned               taken;
    logic [LEN_W-1:0]          chunk_len;
    logic [SYM_W-1:0]          pending_symbols [$];
    int                        errors;
    int                        items;
    int                        loads;
    int                        symbols_seen;

    function new();
      for (int k = 0; k < NTONES; k++) begin
        coeff_tab[k] = '0;
        q1[k] = '0;
        q2[k] = '0;
      end
      taken = 0;
      chunk_len = LEN_RESET;
      errors = 0;
      items = 0;
      loads = 0;
      symbols_seen = 0;
    endfunction

    function automatic logic signed [STATE_W-1:0] filter_update(
        logic signed [COEFF_W-1:0] c, logic signed [STATE_W-1:0] a,
        logic signed [STATE_W-1:0] b, logic signed [SAMPLE_W-1:0] x);
      logic signed [65:0] cw, aw, bw, xw, q0;
      cw = c;
      aw = a;
      bw = b;
      xw = x;
      q0 = ((cw * aw + 66'sd8192) >>> FRAC_W) - bw + xw;
      if (q0 > 66'sd140737488355327) return {1'b0, {(STATE_W-1){1'b1}}};
      if (q0 < -66'sd140737488355328) return {1'b1, {(STATE_W-1){1'b0}}};
      return q0[STATE_W-1:0];
    endfunction

    function automatic logic signed [129:0] tone_power(int k);
      logic signed [129:0] c, a, b;
      c = coeff_tab[k];
      a = q1[k];
      b = q2[k];
      return ((a * a + b * b) <<< FRAC_W) - c * a * b;
    endfunction

    function void take_item(logic cmd, logic signed [SAMPLE_W-1:0] pcm,
                            logic [TIDX_W-1:0] tidx, logic signed [COEFF_W-1:0] tc);
      int unsigned         span;
      int                  best;
      logic signed [129:0] best_p;
      logic signed [129:0] p;
      logic signed [STATE_W-1:0] q0;
      items++;
      if (cmd == CMD_COEFF) begin
        if (tidx < NTONES) coeff_tab[tidx] = tc;
        loads++;
        return;
      end
      for (int k = 0; k < NTONES; k++) begin
        q0 = filter_update(coeff_tab[k], q1[k], q2[k], pcm);
        q2[k] = q1[k];
        q1[k] = q0;
      end
      span = chunk_len;
      if (span == 0) span = 1;
      if (span > MAX_SAMPLES) span = MAX_SAMPLES;
      if (taken + 1 < span) begin
        taken++;
        return;
      end
      best = 0;
      best_p = tone_power(0);
      for (int k = 1; k < NTONES; k++) begin
        p = tone_power(k);
        if (p > best_p) begin
          best_p = p;
          best = k;
        end
      end
      for (int k = 0; k < NTONES; k++) begin
        q1[k] = '0;
        q2[k] = '0;
      end
      taken = 0;
      pending_symbols.insert(pending_symbols.size(), best[SYM_W-1:0]);
    endfunction

    function void check_symbol(logic [SYM_W-1:0] got);
      logic [SYM_W-1:0] want;
      if (pending_symbols.size() == 0) begin
        $error("symbol: none expected, actual %0d", got);
        errors++;
        return;
      end
      want = pending_symbols.pop_front();
      symbols_seen++;
      if (got !== want) begin
        $error("symbol: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_cmd;
  logic signed [SAMPLE_W-1:0] in_pcm_sample;
  logic [TIDX_W-1:0]          in_tone_index;
  logic signed [COEFF_W-1:0]  in_tone_coeff;
  logic                       out_valid;
  logic                       out_stall;
  logic [SYM_W-1:0]           out_symbol;
  logic                       cfg_wr_en;
  logic [LEN_W-1:0]           cfg_wr_data;

  tone_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;
  int hold_served;
  int quiet_cycles;
  int lengths_written;
  int wave_period;
  int wave_amp;
  int wave_pos;

  mfsk16_goertzel_symbol_detector_core #(
    .NUM_TONES          (NTONES),
    .MAX_SYMBOL_SAMPLES (MAX_SAMPLES)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_pcm_sample (in_pcm_sample),
    .in_tone_index (in_tone_index),
    .in_tone_coeff (in_tone_coeff),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_symbol    (out_symbol),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall, plus a long hold-off when asked
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_symbol(out_symbol);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_mfsk16_goertzel_symbol_detector_core: FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic cmd, input logic signed [SAMPLE_W-1:0] pcm,
                           input logic [TIDX_W-1:0] tidx,
                           input logic signed [COEFF_W-1:0] tc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_pcm_sample <= pcm;
    in_tone_index <= tidx;
    in_tone_coeff <= tc;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_item(cmd, pcm, tidx, tc);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    push_item(CMD_SAMPLE, x, TIDX_W'($urandom), COEFF_W'($urandom));
  endtask

  task automatic send_coeff(input logic [TIDX_W-1:0] t, input logic signed [COEFF_W-1:0] c);
    push_item(CMD_COEFF, SAMPLE_W'($urandom), t, c);
  endtask

  // drop valid and wait for every pending symbol
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_symbols.size() != 0);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.chunk_len = v;
    lengths_written++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_pcm();
    int roll;
    int v;
    roll = $urandom_range(99);
    wave_pos++;
    if (roll < 12) begin
      case ($urandom_range(4))
        0:       return 16'sh7fff;
        1:       return 16'sh8000;
        2:       return 16'sh0000;
        3:       return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    if (roll < 45) return SAMPLE_W'($urandom);
    v = ((wave_pos % wave_period) < wave_period / 2) ? wave_amp : -wave_amp;
    v = v + $urandom_range(64) - 32;
    return SAMPLE_W'(v);
  endfunction

  task automatic random_item();
    logic signed [COEFF_W-1:0] c;
    if ($urandom_range(99) < 4) begin
      wave_period = $urandom_range(2, 16);
      wave_amp    = $urandom_range(1, 32000);
    end
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(5))
        0:       c = 16'sh7fff;
        1:       c = 16'sh8000;
        2:       c = 16'sh0000;
        default: c = COEFF_W'($urandom);
      endcase
      send_coeff(TIDX_W'($urandom_range(NTONES - 1)), c);
    end else begin
      send_sample(next_pcm());
    end
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(5))
      0:       return '0;
      1:       return LEN_W'(1);
      2:       return LEN_W'(2);
      3:       return LEN_W'($urandom_range(3, 6));
      4:       return LEN_W'($urandom_range(7, 16));
      default: return LEN_W'($urandom_range(17, 40));
    endcase
  endfunction

  initial begin
    sb = new();
    send_idle_pct   = 32;
    recv_stall_pct  = 60;
    hold_asked      = 0;
    hold_served     = 0;
    quiet_cycles    = 0;
    lengths_written = 0;
    wave_period     = 8;
    wave_amp        = 20000;
    wave_pos        = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_SAMPLE;
    in_pcm_sample <= '0;
    in_tone_index <= '0;
    in_tone_coeff <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full coefficient table, from +max down to the most negative value
    for (int k = 0; k < NTONES; k++)
      send_coeff(TIDX_W'(k), COEFF_W'(32767 - 4369 * k));
    // partial chunk at the reset length, then a shorter length ends it
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    write_length(LEN_W'(2));
    send_sample(-16'sd1000);
    // coefficient load in the middle of a chunk
    send_sample(16'sd12345);
    send_coeff(TIDX_W'(5), 16'sh8000);
    send_sample(-16'sd5);
    // zero length acts as one; an all-zero chunk ties on every tone
    write_length('0);
    send_sample(16'sh0000);
    send_sample(16'sh8000);
    // largest length, left pending, then cut short
    write_length({LEN_W{1'b1}});
    repeat (3) send_sample(SAMPLE_W'($urandom));
    write_length(LEN_W'(1));
    send_sample(16'sh7fff);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 32 : (mode == 1) ? 60 : 0;
      recv_stall_pct = (mode == 0) ? 60 : (mode == 1) ? 32 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        if (mode == 2 && ph == 0) begin
          write_length(LEN_W'(1));
          hold_asked++;
        end else begin
          write_length(pick_length());
        end
        for (int n = 0; n < 28; n++) begin
          random_item();
          if (ph == 2 && n == 14) drain();
        end
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (sb.pending_symbols.size() != 0) begin
      $error("symbol: %0d expected symbols never arrived", sb.pending_symbols.size());
      sb.errors++;
    end
    $display("run covered %0d items (%0d coefficient loads) and %0d checked symbols",
             sb.items, sb.loads, sb.symbols_seen);
    $display("chunk length written %0d times, from zero to the 13-bit maximum",
             lengths_written);
    if (sb.errors == 0) begin
      $display("tb_mfsk16_goertzel_symbol_detector_core: PASS");
    end else begin
      $display("tb_mfsk16_goertzel_symbol_detector_core: FAIL");
    end
    $finish;
  end

endmodule
